// File: rtl/core/bbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Backlight brightness control package
// Widths, reset values, register and function codes, and shared types.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int NUM_LEVELS  = 4;
  localparam int SAMPLE_BITS = 12;

  localparam int LVL_W   = 2;
  localparam int PCT_W   = 7;
  localparam int ADC_W   = 12;
  localparam int FRAC_W  = 8;
  localparam int AVG_W   = ADC_W + FRAC_W;
  localparam int PROD_W  = AVG_W + PCT_W;
  localparam int TIME_W  = 32;
  localparam int HOLD_W  = 20;
  localparam int SHIFT_W = 4;
  localparam int TABLE_W = 32;
  localparam int FUNC_W  = 2;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam int IN_DATA_W  = ((ADC_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((PCT_W + LVL_W + PCT_W + 7) / 8) * 8;

  localparam int MAX_SHIFT = 8;
  localparam int PCT_CAP   = 100;

  localparam logic [ADC_W-1:0] RAW_MASK = ADC_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  localparam logic [TABLE_W-1:0] RST_LEVEL_TABLE  = 32'h644B3219;
  localparam logic [SHIFT_W-1:0] RST_EMA_SHIFT    = 4'd2;
  localparam logic [ADC_W-1:0]   RST_ADC_MIN      = 12'd0;
  localparam logic [ADC_W-1:0]   RST_ADC_MAX      = 12'd4095;
  localparam logic [PCT_W-1:0]   RST_PCT_MIN      = 7'd10;
  localparam logic [PCT_W-1:0]   RST_PCT_MAX      = 7'd100;
  localparam logic [HOLD_W-1:0]  RST_HOLD_MS      = 20'd10000;
  localparam logic [LVL_W-1:0]   RST_LEVEL_INDEX  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_TABLE  = 3'd0,
    CFG_EMA_SHIFT    = 3'd1,
    CFG_ADC_MIN      = 3'd2,
    CFG_ADC_MAX      = 3'd3,
    CFG_INVERT_SENSE = 3'd4,
    CFG_PCT_MIN      = 3'd5,
    CFG_PCT_MAX      = 3'd6,
    CFG_HOLD_MS      = 3'd7
  } cfg_reg_e;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TOUCH  = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_APPLY  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMA,
    ST_MAP,
    ST_CALC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [PCT_W-1:0] quo;
    logic             inexact;
  } muldiv_res_t;

  function automatic logic [PCT_W-1:0] sat_pct(input logic [7:0] v);
    sat_pct = (v > 8'(PCT_CAP)) ? PCT_W'(PCT_CAP) : v[PCT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/bbc_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial multiply-divide
// Computes num * scale / den, one multiplier bit per cycle, then one quotient
// bit per cycle; the quotient is known to stay below 2^PCT_W.
// ----------------------------------------------------------------------------
module bbc_muldiv (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [bbc_pkg::AVG_W-1:0] num,
  input  wire logic [bbc_pkg::PCT_W-1:0] scale,
  input  wire logic [bbc_pkg::AVG_W-1:0] den,
  output logic                          done,
  output bbc_pkg::muldiv_res_t          res
);
  import bbc_pkg::*;

  localparam int CNT_W = $clog2(PCT_W);

  logic              busy;
  logic              div_phase;
  logic [CNT_W-1:0]  cnt;
  logic              last;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] mcand;
  logic [PROD_W-1:0] dsh;
  logic [AVG_W-1:0]  den_q;
  logic [PCT_W-1:0]  mplier;
  logic [PCT_W-1:0]  quo;

  assign last = (cnt == CNT_W'(PCT_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      div_phase <= 1'b0;
      cnt       <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        div_phase <= 1'b0;
        cnt       <= '0;
      end else if (busy) begin
        cnt <= last ? '0 : cnt + CNT_W'(1);
        if (last) begin
          if (div_phase) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            div_phase <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= PROD_W'(num);
      mplier <= scale;
      den_q  <= den;
      quo    <= '0;
    end else if (busy && !div_phase) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      if (last) begin
        dsh <= PROD_W'(den_q) << (PCT_W - 1);
      end
    end else if (busy && div_phase) begin
      if (acc >= dsh) begin
        acc <= acc - dsh;
        quo <= {quo[PCT_W-2:0], 1'b1};
      end else begin
        quo <= {quo[PCT_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign res.quo     = quo;
  assign res.inexact = |acc;

endmodule
`default_nettype wire

// File: rtl/core/backlight_brightness_control.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Backlight brightness control
// Manual level stepping with override hold-off, and an averaged light-sensor
// reading mapped linearly onto a backlight percent.
// ----------------------------------------------------------------------------
// Touch and apply: accepted, then ST_DONE, then the output register once the output is free.
// Sample: average (ST_EMA), window map (ST_MAP), serial multiply then serial divide
//   (ST_CALC), ST_DONE, output register; an empty window skips ST_CALC.
// Ignored samples and unused codes give no result; input ready next cycle.
// One item at a time, ready only while idle.
// Reset (synchronous, active high) loads register defaults and clears state.
// ----------------------------------------------------------------------------
module backlight_brightness_control (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // raw_sample [11:0], now_time [43:12], zero fill [47:44]
  input  wire logic [bbc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func [1:0]
  input  wire logic [bbc_pkg::FUNC_W-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // backlight_percent [6:0], manual_level [8:7], sensor_percent [15:9]
  output logic [bbc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                           cfg_we,
  input  wire bbc_pkg::cfg_reg_e              cfg_index,
  input  wire logic [bbc_pkg::CFG_W-1:0]      cfg_data
);
  import bbc_pkg::*;

  logic [TABLE_W-1:0] level_table;
  logic [SHIFT_W-1:0] ema_shift;
  logic [ADC_W-1:0]   adc_min;
  logic [ADC_W-1:0]   adc_max;
  logic               invert_sense;
  logic [PCT_W-1:0]   pct_min;
  logic [PCT_W-1:0]   pct_max;
  logic [HOLD_W-1:0]  hold_ms;

  logic [LVL_W-1:0]   level_index;
  logic [AVG_W-1:0]   average_q8;
  logic [PCT_W-1:0]   last_sensor_pct;
  logic [TIME_W-1:0]  override_deadline;

  state_t             state;
  state_t             state_next;

  logic [ADC_W-1:0]   raw_q;
  logic [PCT_W-1:0]   pct_q;

  logic               accept;
  logic               out_free;
  func_e              func;
  logic [ADC_W-1:0]   in_raw;
  logic [TIME_W-1:0]  in_now;
  logic               early;

  logic [LVL_W:0]     level_sum;
  logic [LVL_W-1:0]   level_next;
  logic [PCT_W-1:0]   accept_pct;

  logic [PCT_W-1:0]   lo;
  logic [PCT_W-1:0]   hi;
  logic               desc;
  logic [PCT_W-1:0]   span;

  logic [SHIFT_W-1:0] sh;
  logic [AVG_W-1:0]   r_q8;
  logic [AVG_W:0]     dn;
  logic [AVG_W-1:0]   ema_next;

  logic               empty;
  logic [AVG_W-1:0]   wmin;
  logic [AVG_W-1:0]   wmax;
  logic [AVG_W-1:0]   v_lo;
  logic [AVG_W-1:0]   v_cl;
  logic [AVG_W-1:0]   den;
  logic [AVG_W-1:0]   num_raw;
  logic [AVG_W-1:0]   num;

  logic               md_start;
  logic               md_done;
  muldiv_res_t        md_res;
  logic [PCT_W-1:0]   calc_pct;

  function automatic logic [PCT_W-1:0] table_pct(input logic [TABLE_W-1:0] tbl,
                                                 input logic [LVL_W-1:0] idx);
    table_pct = sat_pct(tbl[{idx, 3'b000} +: 8]);
  endfunction

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign func          = func_e'(s_axis_tuser);
  assign in_raw        = s_axis_tdata[ADC_W-1:0] & RAW_MASK;
  assign in_now        = s_axis_tdata[ADC_W+TIME_W-1:ADC_W];
  assign early         = (in_now < override_deadline);

  assign level_sum  = {1'b0, level_index} + (LVL_W+1)'(1);
  assign level_next = (level_sum >= (LVL_W+1)'(NUM_LEVELS))
                    ? LVL_W'(level_sum - (LVL_W+1)'(NUM_LEVELS))
                    : LVL_W'(level_sum);
  assign accept_pct = table_pct(level_table, (func == FUNC_TOUCH) ? level_next : level_index);

  assign lo   = sat_pct({1'b0, pct_min});
  assign hi   = sat_pct({1'b0, pct_max});
  assign desc = (hi < lo);
  assign span = desc ? (lo - hi) : (hi - lo);

  always_comb begin
    sh   = (ema_shift > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : ema_shift;
    r_q8 = {raw_q, {FRAC_W{1'b0}}};
    dn   = {1'b0, average_q8 - r_q8} + (((AVG_W+1)'(1) << sh) - (AVG_W+1)'(1));
    if (r_q8 >= average_q8) begin
      ema_next = average_q8 + ((r_q8 - average_q8) >> sh);
    end else begin
      ema_next = average_q8 - AVG_W'(dn >> sh);
    end
  end

  always_comb begin
    empty   = (adc_max <= adc_min);
    wmin    = {adc_min, {FRAC_W{1'b0}}};
    wmax    = {adc_max, {FRAC_W{1'b0}}};
    v_lo    = (average_q8 < wmin) ? wmin : average_q8;
    v_cl    = (v_lo > wmax) ? wmax : v_lo;
    den     = wmax - wmin;
    num_raw = v_cl - wmin;
    num     = invert_sense ? (den - num_raw) : num_raw;
  end

  assign md_start = (state == ST_MAP) && !empty;
  assign calc_pct = desc ? (lo - (md_res.quo + PCT_W'(md_res.inexact))) : (lo + md_res.quo);

  bbc_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .num   (num),
    .scale (span),
    .den   (den),
    .done  (md_done),
    .res   (md_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (func)
            FUNC_TOUCH, FUNC_APPLY: state_next = ST_DONE;
            FUNC_SAMPLE:            state_next = early ? ST_IDLE : ST_EMA;
            default:                state_next = ST_IDLE;
          endcase
        end
      end
      ST_EMA:  state_next = ST_MAP;
      ST_MAP:  state_next = empty ? ST_DONE : ST_CALC;
      ST_CALC: begin
        if (md_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_table       <= RST_LEVEL_TABLE;
      ema_shift         <= RST_EMA_SHIFT;
      adc_min           <= RST_ADC_MIN;
      adc_max           <= RST_ADC_MAX;
      invert_sense      <= 1'b0;
      pct_min           <= RST_PCT_MIN;
      pct_max           <= RST_PCT_MAX;
      hold_ms           <= RST_HOLD_MS;
      level_index       <= RST_LEVEL_INDEX;
      average_q8        <= '0;
      last_sensor_pct   <= '0;
      override_deadline <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LEVEL_TABLE:  level_table  <= cfg_data[TABLE_W-1:0];
          CFG_EMA_SHIFT:    ema_shift    <= cfg_data[SHIFT_W-1:0];
          CFG_ADC_MIN:      adc_min      <= cfg_data[ADC_W-1:0];
          CFG_ADC_MAX:      adc_max      <= cfg_data[ADC_W-1:0];
          CFG_INVERT_SENSE: invert_sense <= cfg_data[0];
          CFG_PCT_MIN:      pct_min      <= cfg_data[PCT_W-1:0];
          CFG_PCT_MAX:      pct_max      <= cfg_data[PCT_W-1:0];
          CFG_HOLD_MS:      hold_ms      <= cfg_data[HOLD_W-1:0];
          default:          ;
        endcase
      end
      if (accept && (func == FUNC_TOUCH)) begin
        level_index       <= level_next;
        override_deadline <= in_now + TIME_W'(hold_ms);
      end
      if (state == ST_EMA) begin
        average_q8 <= ema_next;
      end
      if ((state == ST_MAP) && empty) begin
        last_sensor_pct <= lo;
      end
      if ((state == ST_CALC) && md_done) begin
        last_sensor_pct <= calc_pct;
      end
      if ((state == ST_DONE) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_q <= in_raw;
      pct_q <= accept_pct;
    end
    if ((state == ST_MAP) && empty) begin
      pct_q <= lo;
    end
    if ((state == ST_CALC) && md_done) begin
      pct_q <= calc_pct;
    end
    if ((state == ST_DONE) && out_free) begin
      m_axis_tdata <= OUT_DATA_W'({last_sensor_pct, level_index, pct_q});
    end
  end

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Backlight brightness control testbench
// Drives touches, light samples, apply requests and unused codes through the
// input stream under several register settings, and predicts each one. The
// prediction covers level stepping, override hold-off with 32-bit wrap, the
// exponential average and the window-to-percent map. Every output
// transaction is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
import bbc_pkg::*;

typedef struct {
  logic [PCT_W-1:0] backlight_pct;
  logic [LVL_W-1:0] level;
  logic [PCT_W-1:0] sensor_pct;
} brightness_t;

class brightness_scoreboard;
  logic [TABLE_W-1:0] level_table;
  logic [SHIFT_W-1:0] ema_shift;
  logic [ADC_W-1:0]   adc_min;
  logic [ADC_W-1:0]   adc_max;
  logic               invert_sense;
  logic [PCT_W-1:0]   pct_min;
  logic [PCT_W-1:0]   pct_max;
  logic [HOLD_W-1:0]  hold_ms;

  logic [LVL_W-1:0]   level_idx;
  logic [AVG_W-1:0]   avg_q8;
  logic [PCT_W-1:0]   sensor_pct;
  logic [TIME_W-1:0]  deadline;

  brightness_t expected_brightness[$];
  int errors;
  int n_checked;
  int n_held_off;

  function new();
    level_table  = RST_LEVEL_TABLE;
    ema_shift    = RST_EMA_SHIFT;
    adc_min      = RST_ADC_MIN;
    adc_max      = RST_ADC_MAX;
    invert_sense = 1'b0;
    pct_min      = RST_PCT_MIN;
    pct_max      = RST_PCT_MAX;
    hold_ms      = RST_HOLD_MS;
    level_idx    = RST_LEVEL_INDEX;
    avg_q8       = '0;
    sensor_pct   = '0;
    deadline     = '0;
  endfunction

  function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_LEVEL_TABLE:  level_table  = val[TABLE_W-1:0];
      CFG_EMA_SHIFT:    ema_shift    = val[SHIFT_W-1:0];
      CFG_ADC_MIN:      adc_min      = val[ADC_W-1:0];
      CFG_ADC_MAX:      adc_max      = val[ADC_W-1:0];
      CFG_INVERT_SENSE: invert_sense = val[0];
      CFG_PCT_MIN:      pct_min      = val[PCT_W-1:0];
      CFG_PCT_MAX:      pct_max      = val[PCT_W-1:0];
      CFG_HOLD_MS:      hold_ms      = val[HOLD_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [PCT_W-1:0] cap100(logic [7:0] v);
    return (v > 8'd100) ? 7'd100 : v[PCT_W-1:0];
  endfunction

  function logic [PCT_W-1:0] map_pct(logic [AVG_W-1:0] avg);
    logic [PCT_W-1:0] lo, hi;
    logic [63:0] wmin, wmax, v, num, den;
    lo = cap100({1'b0, pct_min});
    hi = cap100({1'b0, pct_max});
    if (adc_max <= adc_min) return lo;
    wmin = 64'(adc_min) << FRAC_W;
    wmax = 64'(adc_max) << FRAC_W;
    v = 64'(avg);
    if (v < wmin) v = wmin;
    if (v > wmax) v = wmax;
    den = wmax - wmin;
    num = v - wmin;
    if (invert_sense) num = den - num;
    if (hi >= lo) return lo + PCT_W'((num * 64'(hi - lo)) / den);
    return lo - PCT_W'((num * 64'(lo - hi) + den - 64'd1) / den);
  endfunction

  function void queue_result(logic [PCT_W-1:0] pct);
    brightness_t r;
    r.backlight_pct = pct;
    r.level         = level_idx;
    r.sensor_pct    = sensor_pct;
    expected_brightness.push_back(r);
  endfunction

  function void predict_item(logic [FUNC_W-1:0] f, logic [ADC_W-1:0] raw,
                             logic [TIME_W-1:0] now);
    logic [3:0]  sh;
    logic [63:0] r, a;
    case (f)
      FUNC_TOUCH: begin
        level_idx = LVL_W'((int'(level_idx) + 1) % NUM_LEVELS);
        deadline  = now + TIME_W'(hold_ms);
        queue_result(cap100(level_table[level_idx*8 +: 8]));
      end
      FUNC_APPLY: queue_result(cap100(level_table[level_idx*8 +: 8]));
      FUNC_SAMPLE: begin
        if (now < deadline) begin
          n_held_off++;
        end else begin
          sh = (ema_shift > 4'(MAX_SHIFT)) ? 4'(MAX_SHIFT) : ema_shift;
          r  = 64'(raw) << FRAC_W;
          a  = 64'(avg_q8);
          if (r >= a) a = a + ((r - a) >> sh);
          else a = a - ((a - r + ((64'd1 << sh) - 64'd1)) >> sh);
          avg_q8     = a[AVG_W-1:0];
          sensor_pct = map_pct(avg_q8);
          queue_result(sensor_pct);
        end
      end
      default: ;
    endcase
  endfunction

  function void check_output(logic [OUT_DATA_W-1:0] d);
    brightness_t want;
    if (expected_brightness.size() == 0) begin
      $error("output transaction with nothing pending: tdata=%h", d);
      errors++;
      return;
    end
    want = expected_brightness.pop_front();
    n_checked++;
    if (d[6:0] != want.backlight_pct) begin
      $error("backlight_percent: expected %0d, actual %0d", want.backlight_pct, d[6:0]);
      errors++;
    end
    if (d[8:7] != want.level) begin
      $error("manual_level: expected %0d, actual %0d", want.level, d[8:7]);
      errors++;
    end
    if (d[15:9] != want.sensor_pct) begin
      $error("sensor_percent: expected %0d, actual %0d", want.sensor_pct, d[15:9]);
      errors++;
    end
  endfunction

  function int pending();
    return expected_brightness.size();
  endfunction
endclass

module tb_top;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int QUIET_PHASE     = 5;
  localparam int STALL_PHASE     = 6;
  localparam int DRAIN_CYCLES    = 24;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [FUNC_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  cfg_reg_e              cfg_index = CFG_LEVEL_TABLE;
  logic [CFG_W-1:0]      cfg_data = '0;

  brightness_scoreboard sb = new();
  bit          quiet = 1'b0;
  int          long_hold_req = 0;
  int          hold_left = 0;
  int          n_items = 0;
  logic [31:0] clock_ms = '0;

  backlight_brightness_control dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // output side: check, then pick the next ready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
    if (long_hold_req > 0) begin
      hold_left = long_hold_req;
      long_hold_req = 0;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 10);
    end
  end

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ADC_W-1:0] raw,
                           input logic [TIME_W-1:0] now);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 10) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - ADC_W - TIME_W){1'b0}}, now, raw};
    s_axis_tuser  <= f;
    do @(posedge clk); while (!s_axis_tready);
    sb.predict_item(f, raw, now);
    n_items++;
  endtask

  // drop valid, wait for every pending result, then let the block settle
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // register values in index order
  task automatic pick_settings(input int p, output logic [CFG_W-1:0] v [8]);
    case (p)
      0: v = '{32'hFFFF_FFFF, 0, 0, 4095, 1, 0, 100, 0};
      1: v = '{32'h0000_0000, 8, 1000, 1200, 0, 100, 0, 20'hFFFFF};
      2: v = '{32'h1934_4B64, 15, 4095, 0, 0, 127, 127, 600000};
      3: v = '{32'h0080_6564, 3, 2048, 2048, 1, 37, 90, 5000};
      4: v = '{32'h6465_6663, 1, 0, 1, 1, 0, 127, 1};
      default: begin
        v[CFG_LEVEL_TABLE]  = $urandom;
        v[CFG_EMA_SHIFT]    = $urandom_range(0, 15);
        v[CFG_ADC_MIN]      = $urandom_range(0, 4095);
        v[CFG_ADC_MAX]      = ($urandom_range(0, 99) < 80) ?
                              $urandom_range(v[CFG_ADC_MIN], 4095) : $urandom_range(0, 4095);
        v[CFG_INVERT_SENSE] = $urandom_range(0, 1);
        v[CFG_PCT_MIN]      = $urandom_range(0, 105);
        v[CFG_PCT_MAX]      = $urandom_range(0, 105);
        v[CFG_HOLD_MS]      = ($urandom_range(0, 1) == 0) ?
                              $urandom_range(0, 20000) : $urandom_range(0, 20'hFFFFF);
      end
    endcase
  endtask

  task automatic random_item();
    int pick;
    logic [FUNC_W-1:0] f;
    logic [ADC_W-1:0]  raw;
    logic [TIME_W-1:0] now;
    int unsigned       span;
    pick = $urandom_range(0, 99);
    f = (pick < 10) ? FUNC_TOUCH : (pick < 78) ? FUNC_SAMPLE :
        (pick < 92) ? FUNC_APPLY : FUNC_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 8)       raw = '0;
    else if (pick < 16) raw = '1;
    else if (pick < 24) raw = 12'(sb.adc_min + $urandom_range(0, 4) - 2);
    else if (pick < 32) raw = 12'(sb.adc_max + $urandom_range(0, 4) - 2);
    else                raw = 12'($urandom);
    span = 32'(sb.hold_ms);
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      now = $urandom;
    end else begin
      if (pick < 59)      clock_ms += $urandom_range(0, span / 2 + 20);
      else if (pick < 94) clock_ms += $urandom_range(span, 2 * span + 20);
      else                clock_ms += $urandom;
      now = clock_ms;
    end
    send_item(f, raw, now);
  endtask

  initial begin
    logic [CFG_W-1:0] vals [8];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: levels, hold-off, wrap of the deadline, unused code
    send_item(FUNC_APPLY,  12'h000, 32'd0);
    send_item(FUNC_SAMPLE, 12'hFFF, 32'd0);
    send_item(FUNC_SAMPLE, 12'h000, 32'd5);
    send_item(FUNC_TOUCH,  12'h123, 32'd100);
    send_item(FUNC_SAMPLE, 12'h7D0, 32'd5000);
    send_item(FUNC_UNUSED, 12'hFFF, 32'd20000);
    send_item(FUNC_SAMPLE, 12'hFFF, 32'd10100);
    send_item(FUNC_TOUCH,  12'h000, 32'd200);
    send_item(FUNC_SAMPLE, 12'h800, 32'd10199);
    send_item(FUNC_TOUCH,  12'hFFF, 32'hFFFF_F000);
    send_item(FUNC_SAMPLE, 12'hFFF, 32'hFFFF_FFFF);
    send_item(FUNC_SAMPLE, 12'h000, 32'd0);
    send_item(FUNC_SAMPLE, 12'hFFF, 32'h0000_1710);
    send_item(FUNC_APPLY,  12'h555, 32'd123);
    send_item(FUNC_UNUSED, 12'hABC, 32'h5555_AAAA);
    send_item(FUNC_SAMPLE, 12'h000, 32'd6000);
    send_item(FUNC_SAMPLE, 12'h000, 32'd6001);
    send_item(FUNC_SAMPLE, 12'hFFF, 32'hAAAA_5555);
    send_item(FUNC_SAMPLE, 12'h800, 32'hFFFF_FFFE);
    send_item(FUNC_SAMPLE, 12'h001, 32'hFFFF_FFFF);
    clock_ms = 32'd20000;

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_block();
      pick_settings(p, vals);
      foreach (vals[i]) write_reg(cfg_reg_e'(i), vals[i]);
      cfg_we <= 1'b0;
      quiet = (p == QUIET_PHASE);
      if (p == STALL_PHASE) long_hold_req = 400;
      repeat (ITEMS_PER_PHASE) random_item();
    end
    quiet = 1'b0;
    drain_block();

    $display("Covered %0d input transactions over %0d register settings plus reset values.",
             n_items, NUM_PHASES);
    $display("Checked %0d output transactions; %0d samples fell inside a touch hold-off.",
             sb.n_checked, sb.n_held_off);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// File: files.f
rtl/core/bbc_pkg.sv
rtl/core/bbc_muldiv.sv
rtl/core/backlight_brightness_control.sv
dv/tb_top.sv
